// ----- design/delta_delta_regression_defines.svh -----
// assertion macros shared by the checker
`ifndef DELTA_DELTA_REGRESSION_DEFINES_SVH
`define DELTA_DELTA_REGRESSION_DEFINES_SVH

// property checked on every clock edge outside reset
`define DDR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// signal stays unchanged in the cycle after the condition
`define DDR_ASSERT_HOLD(name, cond, sig, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) else $error(msg);

`endif

// ----- design/ddr_pkg.sv -----
`timescale 1ns / 1ps
package ddr_pkg;

    localparam int MAX_HALF_WINDOW_DEF = 8;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int SCALE_W             = 16;
    localparam int HALF_W              = 4;
    localparam int CFG_DATA_W          = 16;
    localparam int CFG_IDX_W           = 1;

    localparam logic [HALF_W-1:0]  HALF_WINDOW_RESET = 4'd2;
    localparam logic [SCALE_W-1:0] SCALE_RESET       = 16'd6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_WINDOW = 1'b0,
        CFG_SCALE_Q16   = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FRAME,
        S_MREAD,
        S_MLAST,
        S_MSTART,
        S_MSCALE,
        S_VREAD,
        S_VWAIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic clr;
        logic en;
        logic sub;
    } mac_ctrl_t;

endpackage

// ----- design/ddr_ram.sv -----
`timescale 1ns / 1ps
module ddr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/ddr_mac.sv -----
`timescale 1ns / 1ps
module ddr_mac #(
    parameter int SAMPLE_BITS = 16,
    parameter int NW          = 4,
    parameter int ACC_W       = 24
) (
    input  logic                          clk,
    input  ddr_pkg::mac_ctrl_t            ctrl,
    input  logic [NW-1:0]                 n,
    input  logic signed [SAMPLE_BITS-1:0] x,
    output logic signed [ACC_W-1:0]       acc
);

    import ddr_pkg::*;

    localparam int PW = SAMPLE_BITS + NW + 1;

    logic signed [PW-1:0]    prod;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    always_comb
    begin
        prod = $signed({1'b0, n}) * x;
        term = ACC_W'(prod);
        acc_next = acc_reg;
        if (ctrl.clr)
        begin
            acc_next = '0;
        end
        else if (ctrl.en)
        begin
            acc_next = ctrl.sub ? (acc_reg - term) : (acc_reg + term);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ----- design/ddr_scaler.sv -----
`timescale 1ns / 1ps
module ddr_scaler #(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W       = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [ACC_W-1:0]       acc,
    input  logic [ddr_pkg::SCALE_W-1:0]   scale,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] result
);

    import ddr_pkg::*;

    localparam int QW  = ACC_W + 2;
    localparam int CNW = $clog2(SCALE_W + 1);
    localparam logic signed [QW-1:0] QMAX =
        {{(QW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [QW-1:0] QMIN =
        {{(QW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNW-1:0]                cnt_reg;
    logic signed [ACC_W:0]         hi_reg;
    logic [SCALE_W-1:0]            lo_reg;
    logic signed [ACC_W-1:0]       mcand_reg;
    logic [SCALE_W-1:0]            sc_reg;
    logic signed [SAMPLE_BITS-1:0] result_reg;

    logic signed [ACC_W:0]         hi_sum;
    logic signed [QW-1:0]          q;
    logic signed [SAMPLE_BITS-1:0] sat_next;
    logic                          last_step;

    always_comb
    begin
        hi_sum = hi_reg + (sc_reg[0] ? (ACC_W+1)'(mcand_reg) : '0);
        q = QW'(hi_reg) + $signed({{(QW-1){1'b0}}, lo_reg[SCALE_W-1]});
        priority if (q > QMAX)
        begin
            sat_next = QMAX[SAMPLE_BITS-1:0];
        end
        else if (q < QMIN)
        begin
            sat_next = QMIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            sat_next = q[SAMPLE_BITS-1:0];
        end
        last_step = busy_reg && (cnt_reg == CNW'(SCALE_W));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (last_step)
            begin
                busy_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= acc;
            sc_reg    <= scale;
            hi_reg    <= '0;
            lo_reg    <= '0;
        end
        else if (last_step)
        begin
            result_reg <= sat_next;
        end
        else if (busy_reg)
        begin
            hi_reg <= hi_sum >>> 1;
            lo_reg <= {hi_sum[0], lo_reg[SCALE_W-1:1]};
            sc_reg <= sc_reg >> 1;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- design/delta_delta_regression.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// cfg       in         cfg_we                 cfg_index, cfg_data
// in        in         in_valid / in_stall    sample, last
// out       out        out_valid / out_stall  value, delta, delta_delta, end_of_run
//
// the time each emitted frame takes is set by the single sample memory read
// port and the bit-serial scale multiply
// asynchronous active-low reset; memory contents need no clearing
// in_stall is high from acceptance until all frames of the item are queued
// the output register holds a frame while out_stall is high
module delta_delta_regression #(
    parameter int MAX_HALF_WINDOW = ddr_pkg::MAX_HALF_WINDOW_DEF,
    parameter int SAMPLE_BITS     = ddr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ddr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ddr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [SAMPLE_BITS-1:0]    sample,
    input  logic                             last,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [SAMPLE_BITS-1:0]    value,
    output logic signed [SAMPLE_BITS-1:0]    delta,
    output logic signed [SAMPLE_BITS-1:0]    delta_delta,
    output logic                             end_of_run
);

    import ddr_pkg::*;

    localparam int SWIN_DEPTH = 4 * MAX_HALF_WINDOW + 1;
    localparam int RAM_AW     = $clog2(SWIN_DEPTH);
    localparam int RAM_DEPTH  = 1 << RAM_AW;
    localparam int DWIN_DEPTH = 2 * MAX_HALF_WINDOW + 1;
    localparam int CW         = $clog2(SWIN_DEPTH + 1);
    localparam int SAW        = CW + 2;
    localparam int KW         = $clog2(DWIN_DEPTH);
    localparam int NW         = $clog2(MAX_HALF_WINDOW + 1);
    localparam int PW         = $clog2(DWIN_DEPTH + 1);
    localparam int ACC_W      = SAMPLE_BITS + 2 +
                                $clog2(MAX_HALF_WINDOW * (MAX_HALF_WINDOW + 1) / 2);

    state_t state_reg;
    state_t state_next;

    logic [HALF_W-1:0]  half_window_reg;
    logic [SCALE_W-1:0] scale_reg;

    logic [CW-1:0]     cnt_reg;
    logic [PW-1:0]     pend_reg;
    logic [RAM_AW-1:0] head_reg;
    logic              flush_reg;
    logic [KW-1:0]     k_reg;
    logic [NW-1:0]     rn_reg;
    logic              side_reg;
    logic              phase_dd_reg;

    logic                          op_v_reg;
    logic [NW-1:0]                 op_n_reg;
    logic                          op_sub_reg;
    logic                          op_src_reg;
    logic signed [SAMPLE_BITS-1:0] dwin_q_reg;

    logic signed [SAMPLE_BITS-1:0] dwin_reg [DWIN_DEPTH];
    logic signed [SAMPLE_BITS-1:0] val_reg;
    logic signed [SAMPLE_BITS-1:0] dd_reg;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] delta_reg;
    logic signed [SAMPLE_BITS-1:0] dd_out_reg;
    logic                          eor_reg;

    logic [NW-1:0]           nh;
    logic [NW:0]             two_nh;
    logic [PW-1:0]           ta_full;
    logic [KW-1:0]           ta;
    logic [CW-1:0]           lim;
    logic signed [SAW-1:0]   ca_raw;
    logic [CW-1:0]           ca;
    logic signed [SAW-1:0]   rd_raw;
    logic [CW-1:0]           rd_age;
    logic [CW-1:0]           age_sel;
    logic [KW-1:0]           didx;
    logic                    accept;
    logic                    frame_go;
    logic                    last_read;
    logic                    load;
    logic                    k_last;

    logic                          ram_we;
    logic [RAM_AW-1:0]             ram_raddr;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic signed [SAMPLE_BITS-1:0] mac_x;
    mac_ctrl_t                     mac_ctrl;
    logic signed [ACC_W-1:0]       mac_acc;
    logic                          sc_start;
    logic                          sc_done;
    logic signed [SAMPLE_BITS-1:0] sc_result;

    function automatic logic [CW-1:0] clamp_age(input logic signed [SAW-1:0] a,
                                                input logic [CW-1:0] hi);
        logic [CW-1:0] r;
        priority if (a < 0)
        begin
            r = '0;
        end
        else if (a > $signed({2'b00, hi}))
        begin
            r = hi;
        end
        else
        begin
            r = a[CW-1:0];
        end
        return r;
    endfunction

    // effective half window, frame addressing and handshake decodes
    always_comb
    begin
        priority if (half_window_reg == '0)
        begin
            nh = NW'(1);
        end
        else if (half_window_reg > HALF_W'(MAX_HALF_WINDOW))
        begin
            nh = NW'(MAX_HALF_WINDOW);
        end
        else
        begin
            nh = half_window_reg[NW-1:0];
        end
        two_nh  = {nh, 1'b0};
        ta_full = pend_reg - PW'(1);
        ta      = ta_full[KW-1:0];
        lim     = cnt_reg - CW'(1);
        ca_raw  = $signed(SAW'(ta)) + $signed(SAW'(nh)) - $signed(SAW'(k_reg));
        ca      = clamp_age(ca_raw, lim);
        rd_raw  = side_reg ? ($signed({2'b00, ca}) + $signed(SAW'(rn_reg)))
                           : ($signed({2'b00, ca}) - $signed(SAW'(rn_reg)));
        rd_age  = clamp_age(rd_raw, lim);
        age_sel = (state_reg == S_VREAD) ? CW'(ta) : rd_age;
        didx    = side_reg ? (KW'(nh) - KW'(rn_reg)) : (KW'(nh) + KW'(rn_reg));
        ram_raddr = head_reg - RAM_AW'(age_sel);

        accept    = (state_reg == S_IDLE) && in_valid;
        frame_go  = (pend_reg != '0) && (flush_reg || (pend_reg > PW'(two_nh)));
        last_read = (rn_reg == nh) && side_reg;
        load      = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
        k_last    = (k_reg == KW'(two_nh));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_FRAME;
                end
            end
            S_FRAME:
            begin
                state_next = frame_go ? S_MREAD : S_IDLE;
            end
            S_MREAD:
            begin
                if (last_read)
                begin
                    state_next = S_MLAST;
                end
            end
            S_MLAST:
            begin
                state_next = S_MSTART;
            end
            S_MSTART:
            begin
                state_next = S_MSCALE;
            end
            S_MSCALE:
            begin
                if (sc_done)
                begin
                    state_next = phase_dd_reg ? S_VREAD : S_MREAD;
                end
            end
            S_VREAD:
            begin
                state_next = S_VWAIT;
            end
            S_VWAIT:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (load)
                begin
                    state_next = S_FRAME;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        in_stall     = (state_reg != S_IDLE);
        ram_we       = accept;
        sc_start     = (state_reg == S_MSTART);
        mac_ctrl.clr = (state_reg == S_MSTART) || (state_reg == S_FRAME);
        mac_ctrl.en  = op_v_reg;
        mac_ctrl.sub = op_sub_reg;
        mac_x        = op_src_reg ? dwin_q_reg : $signed(ram_rdata);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_window_reg <= HALF_WINDOW_RESET;
            scale_reg       <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_HALF_WINDOW: half_window_reg <= cfg_data[HALF_W-1:0];
                CFG_SCALE_Q16:   scale_reg       <= cfg_data[SCALE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= '0;
            head_reg      <= '0;
            flush_reg     <= 1'b0;
            k_reg         <= '0;
            rn_reg        <= NW'(1);
            side_reg      <= 1'b0;
            phase_dd_reg  <= 1'b0;
            op_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_v_reg      <= (state_reg == S_MREAD);
            out_valid_reg <= load || (out_valid_reg && out_stall);
            if (accept)
            begin
                head_reg  <= head_reg + RAM_AW'(1);
                cnt_reg   <= (cnt_reg == CW'(SWIN_DEPTH)) ? cnt_reg : cnt_reg + CW'(1);
                pend_reg  <= pend_reg + PW'(1);
                flush_reg <= last;
            end
            if (state_reg == S_FRAME)
            begin
                if (pend_reg == '0 && flush_reg)
                begin
                    cnt_reg <= '0;
                end
                k_reg        <= '0;
                rn_reg       <= NW'(1);
                side_reg     <= 1'b0;
                phase_dd_reg <= 1'b0;
            end
            if (state_reg == S_MREAD)
            begin
                if (side_reg)
                begin
                    rn_reg <= rn_reg + NW'(1);
                end
                side_reg <= !side_reg;
            end
            if (state_reg == S_MSCALE && sc_done)
            begin
                rn_reg   <= NW'(1);
                side_reg <= 1'b0;
                if (!phase_dd_reg)
                begin
                    if (k_last)
                    begin
                        phase_dd_reg <= 1'b1;
                    end
                    else
                    begin
                        k_reg <= k_reg + KW'(1);
                    end
                end
            end
            if (load)
            begin
                pend_reg <= pend_reg - PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_n_reg   <= rn_reg;
        op_sub_reg <= side_reg;
        op_src_reg <= phase_dd_reg;
        dwin_q_reg <= dwin_reg[didx];
        if (state_reg == S_MSCALE && sc_done)
        begin
            if (phase_dd_reg)
            begin
                dd_reg <= sc_result;
            end
            else
            begin
                dwin_reg[k_reg] <= sc_result;
            end
        end
        if (state_reg == S_VWAIT)
        begin
            val_reg <= $signed(ram_rdata);
        end
        if (load)
        begin
            value_reg  <= val_reg;
            delta_reg  <= dwin_reg[KW'(nh)];
            dd_out_reg <= dd_reg;
            eor_reg    <= flush_reg && (ta == '0);
        end
    end

    ddr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_reg + RAM_AW'(1)),
        .wdata (sample),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ddr_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .NW          (NW),
        .ACC_W       (ACC_W)
    ) u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .n    (op_n_reg),
        .x    (mac_x),
        .acc  (mac_acc)
    );

    ddr_scaler #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_W       (ACC_W)
    ) u_scaler (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sc_start),
        .acc    (mac_acc),
        .scale  (scale_reg),
        .done   (sc_done),
        .result (sc_result)
    );

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign delta       = delta_reg;
    assign delta_delta = dd_out_reg;
    assign end_of_run  = eor_reg;

endmodule

// ----- design/ddr_checker.sv -----
`timescale 1ns / 1ps
`include "delta_delta_regression_defines.svh"
module ddr_checker #(
    parameter int SAMPLE_BITS = ddr_pkg::SAMPLE_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] value,
    input logic signed [SAMPLE_BITS-1:0] delta,
    input logic signed [SAMPLE_BITS-1:0] delta_delta,
    input logic                          end_of_run
);

    import ddr_pkg::*;

    // an accepted item closes the input in the next cycle
    `DDR_ASSERT(a_accept_busy, in_valid && !in_stall |=> in_stall, "input open after accept")
    // a new item only appears while the block is still working
    `DDR_ASSERT(a_load_busy, $rose(out_valid) |-> in_stall, "item appeared while idle")
    `DDR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "stalled item dropped")
    `DDR_ASSERT_HOLD(a_out_stable, out_valid && out_stall, {value, delta, delta_delta, end_of_run}, "stalled item changed")

endmodule

bind delta_delta_regression ddr_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_ddr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value),
    .delta       (delta),
    .delta_delta (delta_delta),
    .end_of_run  (end_of_run)
);

// ----- tb/delta_delta_regression_tb.sv -----
`timescale 1ns / 1ps
module delta_delta_regression_tb;
    import ddr_pkg::*;

    localparam int MAXN = MAX_HALF_WINDOW_DEF;
    localparam int SDEPTH = 4 * MAXN + 1;
    localparam int WATCH_LIMIT = 200000;

    typedef struct packed {
        logic signed [15:0] value;
        logic signed [15:0] delta;
        logic signed [15:0] delta_delta;
        logic               end_of_run;
    } frame_t;

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
        logic               has_check;
        frame_t             check;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] sample;
    logic last;
    logic out_valid;
    logic out_stall;
    logic signed [15:0] value;
    logic signed [15:0] delta;
    logic signed [15:0] delta_delta;
    logic end_of_run;

    delta_delta_regression i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .last(last),
        .out_valid(out_valid), .out_stall(out_stall), .value(value), .delta(delta),
        .delta_delta(delta_delta), .end_of_run(end_of_run)
    );

    // predictor state
    logic [3:0]  half_reg;
    logic [15:0] scale_reg;
    logic signed [15:0] hist [SDEPTH];
    int seen_cnt;
    int emitted_cnt;

    frame_t pending_frames[$];
    int errors;
    int idle_cnt;
    bit quiet;
    row_t rows[$];

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    function automatic int eff_n();
        int n;
        n = half_reg;
        if (n < 1) n = 1;
        if (n > MAXN) n = MAXN;
        return n;
    endfunction

    function automatic int clip(int j, int top);
        if (j < 0) return 0;
        if (j > top) return top;
        return j;
    endfunction

    function automatic longint hist_at(int j, int top);
        int age;
        age = top - clip(j, top);
        if (age > SDEPTH - 1) age = SDEPTH - 1;
        return hist[age];
    endfunction

    function automatic logic signed [15:0] round_sat(longint acc);
        longint v;
        longint q;
        v = acc * longint'(scale_reg) + 32768;
        q = v >>> 16;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic longint delta_of(int j, int top, int n);
        int c;
        longint acc;
        c = clip(j, top);
        acc = 0;
        for (int k = 1; k <= n; k++)
            acc += k * (hist_at(c + k, top) - hist_at(c - k, top));
        return longint'(round_sat(acc));
    endfunction

    task automatic predict_frames(input logic signed [15:0] s, input logic lst);
        int n;
        int top;
        int t;
        int cnt;
        longint dw [2 * MAXN + 1];
        longint acc;
        frame_t f;
        n = eff_n();
        cnt = 0;
        if (seen_cnt >= 32768)
        begin
            seen_cnt -= 16384;
            emitted_cnt -= 16384;
        end
        for (int i = SDEPTH - 1; i > 0; i--) hist[i] = hist[i - 1];
        hist[0] = s;
        seen_cnt++;
        top = seen_cnt - 1;
        for (t = emitted_cnt; t <= top && cnt < 2 * MAXN + 1; t++)
        begin
            if (!lst && t > top - 2 * n) break;
            for (int k = 0; k <= 2 * n; k++)
                dw[k] = delta_of(clip(t - n + k, top), top, n);
            acc = 0;
            for (int k = 1; k <= n; k++) acc += k * (dw[n + k] - dw[n - k]);
            f.value = 16'(hist_at(t, top));
            f.delta = dw[n][15:0];
            f.delta_delta = round_sat(acc);
            f.end_of_run = lst && (t == top);
            pending_frames.push_back(f);
            cnt++;
        end
        emitted_cnt = t;
        if (lst)
        begin
            seen_cnt = 0;
            emitted_cnt = 0;
        end
    endtask

    // output checker, stall and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_frames.size() == 0)
                begin
                    $display("%0t: unexpected frame %0d %0d %0d %0d", $realtime, value, delta,
                             delta_delta, end_of_run);
                    errors++;
                end
                else
                begin
                    frame_t e;
                    e = pending_frames.pop_front();
                    if (value !== e.value || delta !== e.delta
                        || delta_delta !== e.delta_delta || end_of_run !== e.end_of_run)
                    begin
                        $display("%0t: expected %0d %0d %0d %0d actual %0d %0d %0d %0d",
                                 $realtime, e.value, e.delta, e.delta_delta, e.end_of_run,
                                 value, delta, delta_delta, end_of_run);
                        errors++;
                    end
                end
            end
            if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cnt <= 0;
            else idle_cnt <= idle_cnt + 1;
            if (idle_cnt > WATCH_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        int burst;
        out_stall = 0;
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 5);
                out_stall <= 1;
                repeat (burst) @(posedge clk);
                out_stall <= 0;
            end
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] d);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 0;
        if (idx == CFG_HALF_WINDOW) half_reg = d[3:0];
        else scale_reg = d;
    endtask

    task automatic drain();
        while (pending_frames.size() != 0) @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    // drive one item; held until accepted
    task automatic push_item(input logic signed [15:0] s, input logic lst);
        in_valid <= 1;
        sample <= s;
        last <= lst;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_frames(s, lst);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic add_row(input logic signed [15:0] s, input logic lst);
        row_t r;
        r.sample = s;
        r.last = lst;
        r.has_check = 0;
        r.check = '0;
        rows.push_back(r);
    endtask

    initial
    begin
        int len;
        int mode;
        int total;
        logic signed [15:0] s;
        row_t r;
        errors = 0;
        idle_cnt = 0;
        quiet = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = CFG_HALF_WINDOW;
        cfg_data = '0;
        in_valid = 0;
        sample = '0;
        last = 0;
        half_reg = HALF_WINDOW_RESET;
        scale_reg = SCALE_RESET;
        for (int i = 0; i < SDEPTH; i++) hist[i] = '0;
        seen_cnt = 0;
        emitted_cnt = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // one-frame sequence: value passes, both regressions zero
        r.sample = 16'sh7fff;
        r.last = 1;
        r.has_check = 1;
        r.check = '{16'sh7fff, 16'sd0, 16'sd0, 1'b1};
        rows.push_back(r);
        r.sample = -16'sd32768;
        r.check = '{-16'sd32768, 16'sd0, 16'sd0, 1'b1};
        rows.push_back(r);
        add_row(16'sh7fff, 0);
        add_row(-16'sd32768, 0);
        add_row(16'sh7fff, 0);
        add_row(-16'sd32768, 0);
        add_row(16'sh5555, 0);
        add_row(16'shaaaa, 0);
        add_row(16'sd1, 1);
        add_row(16'sd0, 0);
        add_row(16'sd5, 1);
        add_row(16'sd0, 0);
        add_row(16'sd0, 0);
        add_row(16'sd0, 0);
        add_row(16'sd1, 0);
        add_row(16'sd0, 1);
        foreach (rows[i])
        begin
            if (rows[i].has_check)
            begin
                drain();
                pending_frames.push_back(rows[i].check);
                in_valid <= 1;
                sample <= rows[i].sample;
                last <= rows[i].last;
                @(posedge clk);
                while (in_stall) @(posedge clk);
                in_valid <= 0;
                predict_frames(rows[i].sample, rows[i].last);
                void'(pending_frames.pop_back());
            end
            else
                push_item(rows[i].sample, rows[i].last);
        end
        in_valid <= 0;
        drain();

        // full-scale setting to force saturation, then extremes of the window
        write_reg(CFG_SCALE_Q16, 16'hffff);
        write_reg(CFG_HALF_WINDOW, 4'd8);
        for (int i = 0; i < 10; i++) push_item(i[0] ? 16'sh7fff : -16'sd32768, i == 9);
        in_valid <= 0;
        drain();
        write_reg(CFG_HALF_WINDOW, 4'd0);
        write_reg(CFG_SCALE_Q16, 16'd0);
        for (int i = 0; i < 5; i++) push_item(16'($urandom), i == 4);
        in_valid <= 0;
        drain();

        total = 0;
        while (total < 385)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                mode = $urandom_range(0, 5);
                write_reg(CFG_HALF_WINDOW, mode == 0 ? 4'd15 : 4'($urandom_range(1, 3)));
                write_reg(CFG_SCALE_Q16, mode == 1 ? 16'hffff : 16'($urandom));
            end
            if (total > 310) quiet = 1;
            len = $urandom_range(0, 7) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 9);
            for (int i = 0; i < len; i++)
            begin
                s = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                              : 16'($signed($urandom_range(0, 2000)) - 1000);
                push_item(s, i == len - 1);
                total++;
            end
            in_valid <= 0;
            drain();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
